// ----- rtl/core/rolling_hash_pattern_counter_core_defines.svh -----
// Assertion macros for the rolling hash pattern counter core.
// Used by the port checker; no other dependencies.
`ifndef ROLLING_HASH_PATTERN_COUNTER_CORE_DEFINES_SVH
`define ROLLING_HASH_PATTERN_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RHPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhpc: same-cycle check failed");

// Next-cycle implication, off during reset.
`define RHPC_ASSERT_HOLD(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhpc: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define RHPC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rhpc: post-reset check failed");

`endif

// ----- rtl/core/rhpc_pkg.sv -----
// Shared constants, codes and pipeline types of the rolling hash pattern counter.
// No dependencies.
package rhpc_pkg;

   // default pattern store depth
   localparam int MAX_PATTERN = 64;

   // hash bases, all arithmetic wraps modulo 2^32
   localparam logic [31:0] BASE_A = 32'd32;
   localparam logic [31:0] BASE_B = 32'd37;
   localparam logic [31:0] BASE_C = 32'd41;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // response queue: bounds the transfers in flight
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // request function codes
   localparam logic [1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [1:0] FUNC_PATTERN = 2'd1;
   localparam logic [1:0] FUNC_TEXT    = 2'd2;

   // decoded operation carried down the pipeline
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_PATTERN,
      OP_DROP,
      OP_TEXT
   } op_type;

   typedef struct packed {
      logic       valid;
      op_type     op;
      logic [7:0] char_value;
      logic       use_old;     // outgoing byte comes from the ring
      logic       full_after;  // window holds a whole pattern after this byte
   } stage_type;

   typedef struct packed {
      logic        window_match;
      logic [31:0] match_count;
      logic        pattern_overflow;
   } result_type;

endpackage

// ----- rtl/core/rhpc_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
interface rhpc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] char_value;

   modport source (output valid, output func, output char_value, input ready);
   modport sink (input valid, input func, input char_value, output ready);
endinterface

interface rhpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        window_match;
   logic [31:0] match_count;
   logic        pattern_overflow;

   modport source (output valid, output window_match, output match_count,
                   output pattern_overflow, input ready);
   modport sink (input valid, input window_match, input match_count,
                 input pattern_overflow, output ready);
endinterface

// ----- rtl/core/rhpc_window_ring.sv -----
// Window byte ring: single-port memory, read-before-write, registered read data.
// Depends on rhpc_pkg for the default depth.
module rhpc_window_ring
   import rhpc_pkg::*;
#(
   parameter int Depth = MAX_PATTERN,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic [AddrW-1:0] addr,
   input  logic             wr_en,
   input  logic [7:0]       wr_data,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [Depth];
   logic [7:0] rd_data_ff;

   // old contents come out while the new byte goes in
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr];
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rhpc_seq.sv -----
// Front end: decodes requests, tracks pattern length, window fill and ring pointer.
// Depends on rhpc_pkg; drives rhpc_window_ring.
module rhpc_seq
   import rhpc_pkg::*;
#(
   parameter int MaxPattern = MAX_PATTERN,
   localparam int PtrW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1,
   localparam int LenW = $clog2(MaxPattern + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [1:0]      func,
   input  logic [7:0]      char_value,
   output logic [PtrW-1:0] ring_addr,
   output logic            ring_wr_en,
   output logic [7:0]      ring_wr_data,
   output stage_type       s1
);

   logic [LenW-1:0] length_ff, length_in;
   logic [LenW-1:0] fill_ff, fill_in;
   logic [PtrW-1:0] ptr_ff, ptr_in;
   stage_type       s1_ff, s1_in;
   logic [PtrW-1:0] idx;
   logic [LenW-1:0] idx_inc;
   logic            len_full;
   logic            has_pattern;
   logic            text_write;

   // ring slot for a text byte
   assign idx         = (LenW'(ptr_ff) >= length_ff) ? '0 : ptr_ff;
   assign idx_inc     = LenW'(idx) + LenW'(1);
   assign len_full    = (length_ff >= LenW'(MaxPattern));
   assign has_pattern = (length_ff != '0);

   // request decode and next control state
   always_comb begin
      length_in        = length_ff;
      fill_in          = fill_ff;
      ptr_in           = ptr_ff;
      text_write       = 1'b0;
      s1_in.valid      = accept;
      s1_in.op         = OP_NONE;
      s1_in.char_value = char_value;
      s1_in.use_old    = 1'b0;
      s1_in.full_after = 1'b0;
      unique case (func)
         FUNC_CLEAR: begin
            length_in = '0;
            fill_in   = '0;
            ptr_in    = '0;
            s1_in.op  = OP_CLEAR;
         end
         FUNC_PATTERN: begin
            if (len_full) begin
               s1_in.op = OP_DROP;
            end else begin
               length_in = length_ff + LenW'(1);
               fill_in   = '0;
               ptr_in    = '0;
               s1_in.op  = OP_PATTERN;
            end
         end
         FUNC_TEXT: begin
            if (has_pattern) begin
               text_write       = 1'b1;
               s1_in.op         = OP_TEXT;
               s1_in.use_old    = (fill_ff >= length_ff);
               fill_in          = (fill_ff < length_ff) ? fill_ff + LenW'(1) : fill_ff;
               ptr_in           = (idx_inc >= length_ff) ? '0 : PtrW'(idx_inc);
               s1_in.full_after = (fill_in >= length_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         fill_ff   <= '0;
         ptr_ff    <= '0;
         s1_ff     <= '0;
      end else begin
         if (accept) begin
            length_ff <= length_in;
            fill_ff   <= fill_in;
            ptr_ff    <= ptr_in;
         end
         s1_ff <= s1_in;
      end
   end

   assign ring_addr    = idx;
   assign ring_wr_en   = accept && text_write;
   assign ring_wr_data = char_value;
   assign s1           = s1_ff;

endmodule

// ----- rtl/core/rhpc_hash_unit.sv -----
// Hash datapath: stage 1 rolls the window and pattern hashes, stage 2 compares
// and counts. Depends on rhpc_pkg.
module rhpc_hash_unit
   import rhpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  stage_type  s1,
   input  logic [7:0] old_char,
   output logic       push,
   output result_type result
);

   logic [31:0] ph_a_ff, ph_b_ff, ph_c_ff, ph_a_in, ph_b_in, ph_c_in;
   logic [31:0] wh_a_ff, wh_b_ff, wh_c_ff, wh_a_in, wh_b_in, wh_c_in;
   logic [31:0] bp_a_ff, bp_b_ff, bp_c_ff, bp_a_in, bp_b_in, bp_c_in;
   logic [31:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   stage_type   s2_ff;
   logic [7:0]  old_sel;
   logic [31:0] char32;
   logic        hit;

   assign old_sel = s1.use_old ? old_char : 8'd0;
   assign char32  = {24'd0, s1.char_value};

   // stage 1: Horner step for pattern bytes, roll for text bytes, reset on clear
   always_comb begin
      ph_a_in = ph_a_ff;
      ph_b_in = ph_b_ff;
      ph_c_in = ph_c_ff;
      wh_a_in = wh_a_ff;
      wh_b_in = wh_b_ff;
      wh_c_in = wh_c_ff;
      bp_a_in = bp_a_ff;
      bp_b_in = bp_b_ff;
      bp_c_in = bp_c_ff;
      if (s1.valid) begin
         unique case (s1.op)
            OP_CLEAR: begin
               ph_a_in = '0;
               ph_b_in = '0;
               ph_c_in = '0;
               wh_a_in = '0;
               wh_b_in = '0;
               wh_c_in = '0;
               bp_a_in = 32'd1;
               bp_b_in = 32'd1;
               bp_c_in = 32'd1;
            end
            OP_PATTERN: begin
               ph_a_in = ph_a_ff * BASE_A + char32;
               ph_b_in = ph_b_ff * BASE_B + char32;
               ph_c_in = ph_c_ff * BASE_C + char32;
               bp_a_in = bp_a_ff * BASE_A;
               bp_b_in = bp_b_ff * BASE_B;
               bp_c_in = bp_c_ff * BASE_C;
               wh_a_in = '0;
               wh_b_in = '0;
               wh_c_in = '0;
            end
            OP_TEXT: begin
               wh_a_in = wh_a_ff * BASE_A + char32 - 32'(old_sel) * bp_a_ff;
               wh_b_in = wh_b_ff * BASE_B + char32 - 32'(old_sel) * bp_b_ff;
               wh_c_in = wh_c_ff * BASE_C + char32 - 32'(old_sel) * bp_c_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // stage 2: compare full windows, saturating count, sticky overflow
   assign hit = s2_ff.valid && (s2_ff.op == OP_TEXT) && s2_ff.full_after &&
                (wh_a_ff == ph_a_ff) && (wh_b_ff == ph_b_ff) && (wh_c_ff == ph_c_ff);

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (s2_ff.valid) begin
         unique case (s2_ff.op)
            OP_CLEAR: begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
            OP_DROP: begin
               ovf_in = 1'b1;
            end
            OP_TEXT: begin
               if (hit && (count_ff != COUNT_MAX)) begin
                  count_in = count_ff + 32'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_a_ff  <= '0;
         ph_b_ff  <= '0;
         ph_c_ff  <= '0;
         wh_a_ff  <= '0;
         wh_b_ff  <= '0;
         wh_c_ff  <= '0;
         bp_a_ff  <= 32'd1;
         bp_b_ff  <= 32'd1;
         bp_c_ff  <= 32'd1;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         s2_ff    <= '0;
      end else begin
         ph_a_ff  <= ph_a_in;
         ph_b_ff  <= ph_b_in;
         ph_c_ff  <= ph_c_in;
         wh_a_ff  <= wh_a_in;
         wh_b_ff  <= wh_b_in;
         wh_c_ff  <= wh_c_in;
         bp_a_ff  <= bp_a_in;
         bp_b_ff  <= bp_b_in;
         bp_c_ff  <= bp_c_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         s2_ff    <= s1;
      end
   end

   assign push                    = s2_ff.valid;
   assign result.window_match     = hit;
   assign result.match_count      = count_in;
   assign result.pattern_overflow = ovf_in;

endmodule

// ----- rtl/core/rhpc_rsp_queue.sv -----
// Response queue with credit count: holds finished results and gates request
// ready on the number of transfers in flight. Depends on rhpc_pkg.
module rhpc_rsp_queue
   import rhpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output logic       req_ready,
   output logic       rsp_valid,
   output result_type rsp_data
);

   result_type           slots [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] fill_ff, fill_in;
   logic [RSP_CNT_W-1:0] credit_ff, credit_in;

   // outstanding = accepted but not yet delivered
   assign credit_in = credit_ff + RSP_CNT_W'(accept) - RSP_CNT_W'(pop);
   assign fill_in   = fill_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 :
                         wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 :
                         rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

   assign req_ready = (credit_ff < RSP_CNT_W'(RSP_DEPTH));
   assign rsp_valid = (fill_ff != '0);
   assign rsp_data  = slots[rd_ptr_ff];

endmodule

// ----- rtl/core/rolling_hash_pattern_counter_core.sv -----
// Rolling hash pattern counter: counts places where a loaded pattern matches a
// text stream, using three mod-2^32 polynomial hashes (bases 32, 37, 41). One
// request is taken per clock while request ready is high, and every request
// gives exactly one response, in order. A response is offered once its request
// has moved through the s1 stage register (hash roll with the ring byte), the s2
// stage register (compare and count) and the response queue. The rate of one
// request per clock rests on the window ring memory, which returns the outgoing
// byte and stores the incoming one in the same access, and on the hash roll being
// done in stage 1. Up to four requests may be outstanding; request ready drops
// when four are not yet delivered. Reset is synchronous and there is no memory
// clearing pass.
module rolling_hash_pattern_counter_core
   import rhpc_pkg::*;
#(
   parameter int MaxPattern = MAX_PATTERN
) (
   input  logic      clock,
   input  logic      reset,
   rhpc_req_if.sink  req_ch,
   rhpc_rsp_if.source rsp_ch
);

   localparam int PtrW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

   logic            accept;
   logic            pop;
   logic            credit_ok;
   logic [PtrW-1:0] ring_addr;
   logic            ring_wr_en;
   logic [7:0]      ring_wr_data;
   logic [7:0]      ring_rd_data;
   stage_type       s1;
   logic            push;
   result_type      push_data;
   result_type      rsp_data;
   logic            rsp_valid;

   // channel transfers
   assign accept       = req_ch.valid && credit_ok;
   assign pop          = rsp_valid && rsp_ch.ready;
   assign req_ch.ready = credit_ok;

   rhpc_seq #(
      .MaxPattern(MaxPattern)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_ch.func),
      .char_value  (req_ch.char_value),
      .ring_addr   (ring_addr),
      .ring_wr_en  (ring_wr_en),
      .ring_wr_data(ring_wr_data),
      .s1          (s1)
   );

   rhpc_window_ring #(
      .Depth(MaxPattern)
   ) u_ring (
      .clock  (clock),
      .addr   (ring_addr),
      .wr_en  (ring_wr_en),
      .wr_data(ring_wr_data),
      .rd_data(ring_rd_data)
   );

   rhpc_hash_unit u_hash (
      .clock   (clock),
      .reset   (reset),
      .s1      (s1),
      .old_char(ring_rd_data),
      .push    (push),
      .result  (push_data)
   );

   rhpc_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .req_ready(credit_ok),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // response channel
   assign rsp_ch.valid            = rsp_valid;
   assign rsp_ch.window_match     = rsp_data.window_match;
   assign rsp_ch.match_count      = rsp_data.match_count;
   assign rsp_ch.pattern_overflow = rsp_data.pattern_overflow;

endmodule

// ----- rtl/core/rhpc_checker.sv -----
// Port-level checks for the rolling hash pattern counter, bound to the top level.
// Depends on rolling_hash_pattern_counter_core_defines.svh.
`include "rolling_hash_pattern_counter_core_defines.svh"

module rhpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_window_match,
   input logic [31:0] rsp_match_count
);

   // a stalled response stays offered
   `RHPC_ASSERT_HOLD(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled response keeps its count
   `RHPC_ASSERT_HOLD(a_rsp_count_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_match_count))

   // a reported match is already in the running count
   `RHPC_ASSERT_IMPLY(a_match_counted, clock, reset, rsp_valid && rsp_window_match, rsp_match_count != 32'd0)

   // reset empties the queue and frees all credits
   `RHPC_ASSERT_NEXT(a_reset_empty, clock, reset, req_ready && !rsp_valid)

endmodule

bind rolling_hash_pattern_counter_core rhpc_checker u_rhpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_window_match(rsp_ch.window_match),
   .rsp_match_count (rsp_ch.match_count)
);
